// ===== hw/rtl/i2cm_pkg.sv =====
// Shared types and constants of the I2C register-access master.
package i2cm_pkg;

  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 1'd1;

  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;
  localparam logic [7:0] HALF_PERIOD_RST = 8'd1;
  localparam logic [3:0] BYTE_BITS       = 4'd8;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_PUSH,
    OP_BEGIN_WR,
    OP_BEGIN_RD
  } op_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_ADDR_NACK,
    ST_DATA_NACK,
    ST_REJECT
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_S1,
    PH_S2,
    PH_S3,
    PH_R0,
    PH_R1,
    PH_R2,
    PH_R3,
    PH_TX,
    PH_RXL,
    PH_RXH,
    PH_MAL,
    PH_MAH,
    PH_SP0,
    PH_SP1,
    PH_SP2
  } phase_t;

  typedef enum logic [1:0] {
    K_ADDRW,
    K_REG,
    K_ADDRR,
    K_DATA
  } kind_t;

  typedef enum logic [1:0] {
    SUB_DLOW,
    SUB_DHIGH,
    SUB_ALOW,
    SUB_AHIGH
  } sub_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] write_byte;
    logic       sda_in;
  } cmd_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       done_res;
    status_t    status;
  } res_t;

endpackage

// ===== hw/rtl/i2cm_queue.sv =====
// Two-entry queue used between the front, the engine and the result ports.
module i2cm_queue #(
  parameter int W = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);

  logic [W-1:0] d0_r, d1_r;
  logic [1:0]   cnt_r;
  logic         push_ok, pop_ok;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign push_ok  = push & ~full;
  assign pop_ok   = pop & ~empty;
  assign pop_data = d0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      case ({push_ok, pop_ok})
        2'b10: cnt_r <= cnt_r + 2'd1;
        2'b01: cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push_ok, pop_ok})
      2'b10: begin
        if (cnt_r == 2'd0) begin
          d0_r <= push_data;
        end else begin
          d1_r <= push_data;
        end
      end
      2'b01: d0_r <= d1_r;
      2'b11: begin
        if (cnt_r == 2'd1) begin
          d0_r <= push_data;
        end else begin
          d0_r <= d1_r;
          d1_r <= push_data;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/i2cm_front.sv =====
// Front end: decodes input transactions into commands and queues them.
module i2cm_front import i2cm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [1:0] in_action,
  input  logic [7:0] in_dev_addr,
  input  logic [7:0] in_reg_addr,
  input  logic [7:0] in_byte_count,
  input  logic [7:0] in_write_byte,
  input  logic       in_sda_in,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_take
);

  cmd_t cmd_in;
  logic cmd_empty;

  always_comb begin
    cmd_in            = '0;
    cmd_in.dev_addr   = in_dev_addr;
    cmd_in.reg_addr   = in_reg_addr;
    cmd_in.byte_count = in_byte_count;
    cmd_in.write_byte = in_write_byte;
    cmd_in.sda_in     = in_sda_in;
    unique case (in_action)
      2'd0:    cmd_in.op = OP_TICK;
      2'd1:    cmd_in.op = OP_PUSH;
      2'd2:    cmd_in.op = OP_BEGIN_WR;
      default: cmd_in.op = OP_BEGIN_RD;
    endcase
  end

  i2cm_queue #(.W($bits(cmd_t))) u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_data (cmd_in),
    .full      (in_full),
    .pop       (cmd_take),
    .pop_data  (cmd),
    .empty     (cmd_empty)
  );

  assign cmd_valid = ~cmd_empty;

endmodule

// ===== hw/rtl/i2cm_engine.sv =====
// Back end: line-phase sequencer, write data FIFO and configuration registers.
module i2cm_engine import i2cm_pkg::*; #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata,
  input  logic                 cmd_valid,
  input  cmd_t                 cmd,
  output logic                 cmd_take,
  input  logic                 res_full,
  output logic                 res_push,
  output res_t                 res
);

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FW = $clog2(FIFO_DEPTH + 1);
  localparam int CW = (FW > 8) ? FW : 8;

  logic [7:0] ack_to_r, half_r;

  phase_t     phase_r, phase_nxt;
  kind_t      kind_r, kind_nxt;
  sub_t       sub_r, sub_nxt;
  logic [3:0] bit_r, bit_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] left_r, left_nxt;
  logic [7:0] wait_r, wait_nxt;
  logic [7:0] tick_r, tick_nxt;
  status_t    fail_r, fail_nxt;
  logic [7:0] addr_r, addr_nxt;
  logic [7:0] reg_r, reg_nxt;
  logic       is_read_r, is_read_nxt;

  logic [AW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [7:0]    head_data_r;
  logic [7:0]    fifo_mem [FIFO_DEPTH];

  logic          fire, push_en, pop_en, drain_en;
  logic          ev_reject, ev_rx, ev_done;
  logic [7:0]    hp, tick_inc, ack_tick, left_dec, rx_shift;
  logic [3:0]    bit_inc;
  logic          ack_phase, ack_ripe, ack_expired;
  logic [CW-1:0] left_cw, fill_cw, drain_cw;
  logic [FW-1:0] drain_n;
  logic [FW:0]   skip_sum;
  logic [AW-1:0] head_inc, tail_inc, head_skip;

  assign fire     = cmd_valid & ~res_full;
  assign cmd_take = fire;
  assign res_push = fire;

  assign hp          = (half_r == 8'd0) ? 8'd1 : half_r;
  assign tick_inc    = tick_r + 8'd1;
  assign bit_inc     = bit_r + 4'd1;
  assign left_dec    = left_r - 8'd1;
  assign rx_shift    = {shift_r[6:0], cmd.sda_in};
  assign ack_phase   = (phase_r == PH_TX) && (sub_r == SUB_AHIGH);
  assign ack_tick    = (tick_r < hp) ? tick_inc : tick_r;
  assign ack_ripe    = (ack_tick >= hp);
  assign ack_expired = (wait_r >= ack_to_r);

  assign left_cw   = CW'(left_r);
  assign fill_cw   = CW'(fill_r);
  assign drain_cw  = (left_cw < fill_cw) ? left_cw : fill_cw;
  assign drain_n   = drain_cw[FW-1:0];
  assign skip_sum  = (FW+1)'(head_r) + (FW+1)'(drain_n);
  assign head_skip = (skip_sum >= (FW+1)'(FIFO_DEPTH)) ?
                     AW'(skip_sum - (FW+1)'(FIFO_DEPTH)) : AW'(skip_sum);
  assign head_inc  = (head_r == AW'(FIFO_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc  = (tail_r == AW'(FIFO_DEPTH - 1)) ? '0 : tail_r + 1'b1;

  always_comb begin
    phase_nxt   = phase_r;
    kind_nxt    = kind_r;
    sub_nxt     = sub_r;
    bit_nxt     = bit_r;
    shift_nxt   = shift_r;
    left_nxt    = left_r;
    wait_nxt    = wait_r;
    tick_nxt    = tick_r;
    fail_nxt    = fail_r;
    addr_nxt    = addr_r;
    reg_nxt     = reg_r;
    is_read_nxt = is_read_r;
    push_en     = 1'b0;
    pop_en      = 1'b0;
    drain_en    = 1'b0;
    ev_reject   = 1'b0;
    ev_rx       = 1'b0;
    ev_done     = 1'b0;
    if (fire) begin
      unique case (cmd.op)
        OP_PUSH: begin
          if (fill_r < FW'(FIFO_DEPTH)) begin
            push_en = 1'b1;
          end else begin
            ev_reject = 1'b1;
          end
        end
        OP_BEGIN_WR, OP_BEGIN_RD: begin
          if (phase_r != PH_IDLE ||
              (cmd.op == OP_BEGIN_WR && CW'(cmd.byte_count) > fill_cw)) begin
            ev_reject = 1'b1;
          end else begin
            addr_nxt    = cmd.dev_addr;
            reg_nxt     = cmd.reg_addr;
            left_nxt    = cmd.byte_count;
            is_read_nxt = (cmd.op == OP_BEGIN_RD);
            fail_nxt    = ST_OK;
            wait_nxt    = 8'd0;
            phase_nxt   = PH_S1;
            tick_nxt    = 8'd0;
          end
        end
        default: begin
          if (ack_phase) begin
            tick_nxt = ack_tick;
            if (ack_ripe) begin
              if (cmd.sda_in && !ack_expired) begin
                wait_nxt = wait_r + 8'd1;
              end else begin
                tick_nxt = 8'd0;
                unique case (kind_r)
                  K_ADDRW: begin
                    if (!cmd.sda_in) begin
                      shift_nxt = reg_r;
                      bit_nxt   = 4'd0;
                      kind_nxt  = K_REG;
                      sub_nxt   = SUB_DLOW;
                    end else begin
                      fail_nxt  = ST_ADDR_NACK;
                      drain_en  = 1'b1;
                      left_nxt  = 8'd0;
                      phase_nxt = PH_SP0;
                    end
                  end
                  K_REG, K_DATA: begin
                    if (kind_r == K_REG && is_read_r) begin
                      phase_nxt = PH_R0;
                    end else if (kind_r == K_DATA && cmd.sda_in) begin
                      fail_nxt  = ST_DATA_NACK;
                      drain_en  = 1'b1;
                      left_nxt  = 8'd0;
                      phase_nxt = PH_SP0;
                    end else if (left_r != 8'd0) begin
                      left_nxt  = left_dec;
                      pop_en    = 1'b1;
                      shift_nxt = head_data_r;
                      bit_nxt   = 4'd0;
                      kind_nxt  = K_DATA;
                      sub_nxt   = SUB_DLOW;
                    end else begin
                      phase_nxt = PH_SP0;
                    end
                  end
                  default: begin
                    if (left_r != 8'd0) begin
                      bit_nxt   = 4'd0;
                      shift_nxt = 8'd0;
                      phase_nxt = PH_RXL;
                    end else begin
                      phase_nxt = PH_SP0;
                    end
                  end
                endcase
              end
            end
          end else if (phase_r != PH_IDLE) begin
            if (tick_inc < hp) begin
              tick_nxt = tick_inc;
            end else begin
              tick_nxt = 8'd0;
              unique case (phase_r)
                PH_S1: phase_nxt = PH_S2;
                PH_S2: phase_nxt = PH_S3;
                PH_S3: begin
                  shift_nxt = {addr_r[7:1], 1'b0};
                  bit_nxt   = 4'd0;
                  kind_nxt  = K_ADDRW;
                  sub_nxt   = SUB_DLOW;
                  phase_nxt = PH_TX;
                end
                PH_R0: phase_nxt = PH_R1;
                PH_R1: phase_nxt = PH_R2;
                PH_R2: phase_nxt = PH_R3;
                PH_R3: begin
                  shift_nxt = {addr_r[7:1], 1'b1};
                  bit_nxt   = 4'd0;
                  kind_nxt  = K_ADDRR;
                  sub_nxt   = SUB_DLOW;
                  phase_nxt = PH_TX;
                end
                PH_RXL: phase_nxt = PH_RXH;
                PH_RXH: begin
                  shift_nxt = rx_shift;
                  bit_nxt   = bit_inc;
                  if (bit_inc >= BYTE_BITS) begin
                    ev_rx     = 1'b1;
                    phase_nxt = PH_MAL;
                  end else begin
                    phase_nxt = PH_RXL;
                  end
                end
                PH_MAL: phase_nxt = PH_MAH;
                PH_MAH: begin
                  if (left_r != 8'd0) begin
                    left_nxt = left_dec;
                  end
                  if (left_r > 8'd1) begin
                    bit_nxt   = 4'd0;
                    shift_nxt = 8'd0;
                    phase_nxt = PH_RXL;
                  end else begin
                    phase_nxt = PH_SP0;
                  end
                end
                PH_SP0: phase_nxt = PH_SP1;
                PH_SP1: phase_nxt = PH_SP2;
                PH_SP2: begin
                  phase_nxt = PH_IDLE;
                  ev_done   = 1'b1;
                  fail_nxt  = ST_OK;
                end
                PH_TX: begin
                  unique case (sub_r)
                    SUB_DLOW: sub_nxt = SUB_DHIGH;
                    SUB_DHIGH: begin
                      shift_nxt = {shift_r[6:0], 1'b0};
                      bit_nxt   = bit_inc;
                      sub_nxt   = (bit_inc >= BYTE_BITS) ? SUB_ALOW : SUB_DLOW;
                    end
                    default: begin
                      wait_nxt = 8'd0;
                      sub_nxt  = SUB_AHIGH;
                    end
                  endcase
                end
                default: phase_nxt = PH_IDLE;
              endcase
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    res            = '0;
    res.scl_level  = 1'b1;
    res.sda_level  = 1'b1;
    res.sda_drive  = 1'b1;
    unique case (phase_nxt)
      PH_S2, PH_R2, PH_SP1: res.sda_level = 1'b0;
      PH_S3, PH_R3, PH_SP0: begin
        res.scl_level = 1'b0;
        res.sda_level = 1'b0;
      end
      PH_R0: res.scl_level = 1'b0;
      PH_RXL: begin
        res.scl_level = 1'b0;
        res.sda_drive = 1'b0;
      end
      PH_RXH: res.sda_drive = 1'b0;
      PH_MAL: begin
        res.scl_level = 1'b0;
        res.sda_level = (left_nxt == 8'd1);
      end
      PH_MAH: res.sda_level = (left_nxt == 8'd1);
      PH_TX: begin
        res.scl_level = sub_nxt[0];
        if (sub_nxt == SUB_DLOW || sub_nxt == SUB_DHIGH) begin
          res.sda_level = shift_nxt[7];
        end else begin
          res.sda_drive = 1'b0;
        end
      end
      default: ;
    endcase
    res.busy_res   = (phase_nxt != PH_IDLE);
    res.read_valid = ev_rx;
    res.read_byte  = ev_rx ? rx_shift : 8'd0;
    res.done_res   = ev_done;
    if (ev_reject) begin
      res.status = ST_REJECT;
    end else if (ev_done) begin
      res.status = fail_r;
    end
  end

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    if (push_en) begin
      tail_nxt = tail_inc;
      fill_nxt = fill_r + 1'b1;
    end else if (pop_en) begin
      head_nxt = head_inc;
      fill_nxt = fill_r - 1'b1;
    end else if (drain_en) begin
      head_nxt = head_skip;
      fill_nxt = fill_r - drain_n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_to_r <= ACK_TIMEOUT_RST;
      half_r   <= HALF_PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACK_TIMEOUT: ack_to_r <= cfg_wdata;
        CFG_HALF_PERIOD: half_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      kind_r    <= K_ADDRW;
      sub_r     <= SUB_DLOW;
      bit_r     <= 4'd0;
      shift_r   <= 8'd0;
      left_r    <= 8'd0;
      wait_r    <= 8'd0;
      tick_r    <= 8'd0;
      fail_r    <= ST_OK;
      addr_r    <= 8'd0;
      reg_r     <= 8'd0;
      is_read_r <= 1'b0;
      head_r    <= '0;
      tail_r    <= '0;
      fill_r    <= '0;
    end else begin
      phase_r   <= phase_nxt;
      kind_r    <= kind_nxt;
      sub_r     <= sub_nxt;
      bit_r     <= bit_nxt;
      shift_r   <= shift_nxt;
      left_r    <= left_nxt;
      wait_r    <= wait_nxt;
      tick_r    <= tick_nxt;
      fail_r    <= fail_nxt;
      addr_r    <= addr_nxt;
      reg_r     <= reg_nxt;
      is_read_r <= is_read_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      fill_r    <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      fifo_mem[tail_r] <= cmd.write_byte;
    end
    head_data_r <= (push_en && tail_r == head_nxt) ? cmd.write_byte : fifo_mem[head_nxt];
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(FIFO_DEPTH))
    else $error("write FIFO fill above depth");

  a_write_backed: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE && !is_read_r) |-> left_cw <= fill_cw)
    else $error("write transfer has fewer queued bytes than remaining");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop_en |-> fill_r != '0)
    else $error("pop from empty write FIFO");

  a_rx_source: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.read_valid) |=> phase_r == PH_MAL)
    else $error("received byte reported outside the read phase");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.done_res) |=> phase_r == PH_IDLE && fail_r == ST_OK)
    else $error("transfer done without returning to idle");

endmodule

// ===== hw/rtl/i2c_master_register_access.sv =====
// Top level of the I2C register-access master: front, engine and result queue.
//
//  channel   ports                       transfer when
//  input     in_push / in_full / in_*    in_push && !in_full
//  result    out_pop / out_empty / out_* out_pop && !out_empty
//  config    cfg_we / cfg_index / cfg_*  cfg_we
//
// One transaction per cycle each way while results drain; each input gives one result.
// A command passes the command queue register, then the engine step into the result queue.
// The engine runs one command per cycle from the two-entry queue while res_full is low.
// A stalled result queue holds the engine; up to two commands then wait before in_full.
// rst_n is synchronous; after reset the block accepts immediately, no clearing pass.
module i2c_master_register_access import i2cm_pkg::*; #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [1:0]           in_action,
  input  logic [7:0]           in_dev_addr,
  input  logic [7:0]           in_reg_addr,
  input  logic [7:0]           in_byte_count,
  input  logic [7:0]           in_write_byte,
  input  logic                 in_sda_in,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic                 out_scl_level,
  output logic                 out_sda_level,
  output logic                 out_sda_drive,
  output logic                 out_busy_res,
  output logic [7:0]           out_read_byte,
  output logic                 out_read_valid,
  output logic                 out_done_res,
  output logic [1:0]           out_status
);

  logic cmd_valid, cmd_take, res_full, res_push;
  cmd_t cmd;
  res_t res, res_head;

  i2cm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_action     (in_action),
    .in_dev_addr   (in_dev_addr),
    .in_reg_addr   (in_reg_addr),
    .in_byte_count (in_byte_count),
    .in_write_byte (in_write_byte),
    .in_sda_in     (in_sda_in),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_take      (cmd_take)
  );

  i2cm_engine #(.FIFO_DEPTH(FIFO_DEPTH)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  i2cm_queue #(.W($bits(res_t))) u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (res_head),
    .empty     (out_empty)
  );

  assign out_scl_level  = res_head.scl_level;
  assign out_sda_level  = res_head.sda_level;
  assign out_sda_drive  = res_head.sda_drive;
  assign out_busy_res   = res_head.busy_res;
  assign out_read_byte  = res_head.read_byte;
  assign out_read_valid = res_head.read_valid;
  assign out_done_res   = res_head.done_res;
  assign out_status     = res_head.status;

endmodule

// ===== tb/sv/i2c_master_register_access_test.sv =====
// Self-checking testbench of the I2C register-access master with a line-level predictor.
module i2c_master_register_access_test;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cm_pkg::*;

  localparam int unsigned WFIFO_SLOTS  = 16;
  localparam int unsigned LIMIT_CYCLES = 400000;

  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index     = CFG_ACK_TIMEOUT;
  logic [7:0]           cfg_wdata     = '0;
  logic                 in_push       = 1'b0;
  logic                 in_full;
  logic [1:0]           in_action     = OP_TICK;
  logic [7:0]           in_dev_addr   = '0;
  logic [7:0]           in_reg_addr   = '0;
  logic [7:0]           in_byte_count = '0;
  logic [7:0]           in_write_byte = '0;
  logic                 in_sda_in     = 1'b0;
  logic                 out_empty;
  logic                 out_pop       = 1'b0;
  logic                 out_scl_level;
  logic                 out_sda_level;
  logic                 out_sda_drive;
  logic                 out_busy_res;
  logic [7:0]           out_read_byte;
  logic                 out_read_valid;
  logic                 out_done_res;
  logic [1:0]           out_status;

  i2c_master_register_access dut (.*);

  // predicted bus engine
  logic [7:0] ack_limit  = ACK_TIMEOUT_RST;
  logic [7:0] half_cfg   = HALF_PERIOD_RST;
  phase_t     bus_ph     = PH_IDLE;
  kind_t      bus_kind   = K_ADDRW;
  sub_t       bus_sub    = SUB_DLOW;
  logic [3:0] bit_cnt    = '0;
  logic [7:0] shift_q    = '0;
  logic [7:0] bytes_left = '0;
  logic [7:0] ack_wait   = '0;
  logic [7:0] tick_cnt   = '0;
  logic [7:0] addr_q     = '0;
  logic [7:0] reg_q      = '0;
  logic       rd_q       = 1'b0;
  status_t    fail_q     = ST_OK;
  logic [7:0] wr_fifo[$];

  res_t        res_due[$];
  logic [3:0]  nack_mask     = '0;
  int unsigned nack_pct      = 0;
  int unsigned send_idle_pct = 0;
  int unsigned pop_stall_pct = 0;
  int unsigned hold_left     = 0;
  int unsigned cyc           = 0;
  int unsigned n_err         = 0;
  int unsigned n_sent        = 0;
  int unsigned n_done        = 0;
  int unsigned n_nack        = 0;
  int unsigned n_rbytes      = 0;
  int unsigned n_refused     = 0;

  always #5 clk = ~clk;

  function automatic void enter(phase_t p);
    bus_ph = p;
    tick_cnt = '0;
  endfunction

  function automatic void load_byte(kind_t k, logic [7:0] b);
    shift_q = b;
    bit_cnt = '0;
    bus_kind = k;
    bus_sub = SUB_DLOW;
    enter(PH_TX);
  endfunction

  function automatic logic [7:0] fifo_pop();
    if (wr_fifo.size() == 0) return '0;
    return wr_fifo.pop_front();
  endfunction

  function automatic void send_next_data();
    if (bytes_left != 0) begin
      bytes_left--;
      load_byte(K_DATA, fifo_pop());
    end else begin
      enter(PH_SP0);
    end
  endfunction

  function automatic void abort_xfer(status_t code);
    fail_q = code;
    while (bytes_left != 0 && wr_fifo.size() != 0) begin
      void'(wr_fifo.pop_front());
      bytes_left--;
    end
    bytes_left = '0;
    enter(PH_SP0);
  endfunction

  function automatic void ack_done(logic acked);
    case (bus_kind)
      K_ADDRW: begin
        if (acked) load_byte(K_REG, reg_q);
        else abort_xfer(ST_ADDR_NACK);
      end
      K_REG: begin
        if (rd_q) enter(PH_R0);
        else send_next_data();
      end
      K_ADDRR: begin
        if (bytes_left != 0) begin
          bit_cnt = '0;
          shift_q = '0;
          enter(PH_RXL);
        end else begin
          enter(PH_SP0);
        end
      end
      default: begin
        if (acked) send_next_data();
        else abort_xfer(ST_DATA_NACK);
      end
    endcase
  endfunction

  function automatic void bus_tick(logic sda, inout res_t r);
    logic [7:0] hp;
    hp = (half_cfg == 0) ? 8'd1 : half_cfg;
    if (bus_ph == PH_IDLE) return;
    if (bus_ph == PH_TX && bus_sub == SUB_AHIGH) begin
      if (tick_cnt < hp) tick_cnt++;
      if (tick_cnt < hp) return;
      if (!sda) ack_done(1'b1);
      else if (ack_wait >= ack_limit) ack_done(1'b0);
      else ack_wait++;
      return;
    end
    tick_cnt++;
    if (tick_cnt < hp) return;
    tick_cnt = '0;
    case (bus_ph)
      PH_S1: enter(PH_S2);
      PH_S2: enter(PH_S3);
      PH_S3: load_byte(K_ADDRW, {addr_q[7:1], 1'b0});
      PH_R0: enter(PH_R1);
      PH_R1: enter(PH_R2);
      PH_R2: enter(PH_R3);
      PH_R3: load_byte(K_ADDRR, {addr_q[7:1], 1'b1});
      PH_RXL: enter(PH_RXH);
      PH_RXH: begin
        shift_q = {shift_q[6:0], sda};
        bit_cnt++;
        if (bit_cnt >= BYTE_BITS) begin
          r.read_byte = shift_q;
          r.read_valid = 1'b1;
          enter(PH_MAL);
        end else begin
          enter(PH_RXL);
        end
      end
      PH_MAL: enter(PH_MAH);
      PH_MAH: begin
        if (bytes_left != 0) bytes_left--;
        if (bytes_left != 0) begin
          bit_cnt = '0;
          shift_q = '0;
          enter(PH_RXL);
        end else begin
          enter(PH_SP0);
        end
      end
      PH_SP0: enter(PH_SP1);
      PH_SP1: enter(PH_SP2);
      PH_SP2: begin
        enter(PH_IDLE);
        r.done_res = 1'b1;
        r.status = fail_q;
        fail_q = ST_OK;
      end
      PH_TX: begin
        case (bus_sub)
          SUB_DLOW: bus_sub = SUB_DHIGH;
          SUB_DHIGH: begin
            shift_q = shift_q << 1;
            bit_cnt++;
            if (bit_cnt >= BYTE_BITS) bus_sub = SUB_ALOW;
            else bus_sub = SUB_DLOW;
          end
          default: begin
            ack_wait = '0;
            bus_sub = SUB_AHIGH;
          end
        endcase
        tick_cnt = '0;
      end
      default: enter(PH_IDLE);
    endcase
  endfunction

  function automatic res_t i2c_step(cmd_t c);
    res_t r;
    r = '0;
    case (c.op)
      OP_PUSH: begin
        if (wr_fifo.size() < WFIFO_SLOTS) wr_fifo.push_back(c.write_byte);
        else r.status = ST_REJECT;
      end
      OP_BEGIN_WR, OP_BEGIN_RD: begin
        if (bus_ph != PH_IDLE || (c.op == OP_BEGIN_WR && c.byte_count > wr_fifo.size())) begin
          r.status = ST_REJECT;
        end else begin
          addr_q = c.dev_addr;
          reg_q = c.reg_addr;
          bytes_left = c.byte_count;
          rd_q = (c.op == OP_BEGIN_RD);
          fail_q = ST_OK;
          ack_wait = '0;
          enter(PH_S1);
        end
      end
      default: bus_tick(c.sda_in, r);
    endcase
    r.scl_level = 1'b1;
    r.sda_level = 1'b1;
    r.sda_drive = 1'b1;
    case (bus_ph)
      PH_S2, PH_R2, PH_SP1: r.sda_level = 1'b0;
      PH_S3, PH_R3, PH_SP0: begin
        r.scl_level = 1'b0;
        r.sda_level = 1'b0;
      end
      PH_R0: r.scl_level = 1'b0;
      PH_RXL: begin
        r.scl_level = 1'b0;
        r.sda_drive = 1'b0;
      end
      PH_RXH: r.sda_drive = 1'b0;
      PH_MAL: begin
        r.scl_level = 1'b0;
        r.sda_level = (bytes_left == 1);
      end
      PH_MAH: r.sda_level = (bytes_left == 1);
      PH_TX: begin
        r.scl_level = bus_sub[0];
        if (bus_sub == SUB_DLOW || bus_sub == SUB_DHIGH) r.sda_level = shift_q[7];
        else r.sda_drive = 1'b0;
      end
      default: ;
    endcase
    r.busy_res = (bus_ph != PH_IDLE);
    return r;
  endfunction

  function automatic cmd_t rand_cmd(op_t op);
    cmd_t c;
    c.op = op;
    c.dev_addr = 8'($urandom_range(255));
    c.reg_addr = 8'($urandom_range(255));
    c.byte_count = 8'($urandom_range(255));
    c.write_byte = 8'($urandom_range(255));
    c.sda_in = 1'($urandom_range(1));
    return c;
  endfunction

  // device side: hold SDA high on acknowledge for the selected byte kinds, or at random by nack_pct
  function automatic cmd_t tick_cmd();
    cmd_t c;
    c = rand_cmd(OP_TICK);
    if (bus_ph == PH_TX && bus_sub == SUB_AHIGH)
      c.sda_in = nack_mask[bus_kind] || ($urandom_range(99) < nack_pct);
    return c;
  endfunction

  function automatic void set_nack(logic [3:0] mask, int unsigned pct);
    nack_mask = mask;
    nack_pct = pct;
  endfunction

  task automatic send_cmd(cmd_t c);
    res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_action <= c.op;
    in_dev_addr <= c.dev_addr;
    in_reg_addr <= c.reg_addr;
    in_byte_count <= c.byte_count;
    in_write_byte <= c.write_byte;
    in_sda_in <= c.sda_in;
    do @(posedge clk); while (in_full);
    r = i2c_step(c);
    res_due.push_back(r);
    n_sent++;
    if (r.done_res) n_done++;
    if (r.done_res && r.status != ST_OK) n_nack++;
    if (r.read_valid) n_rbytes++;
    if (!r.done_res && r.status == ST_REJECT) n_refused++;
  endtask

  task automatic push_byte(logic [7:0] b);
    cmd_t c;
    c = rand_cmd(OP_PUSH);
    c.write_byte = b;
    send_cmd(c);
  endtask

  task automatic start_xfer(op_t op, logic [7:0] a, logic [7:0] r, logic [7:0] n);
    cmd_t c;
    c = rand_cmd(op);
    c.dev_addr = a;
    c.reg_addr = r;
    c.byte_count = n;
    send_cmd(c);
  endtask

  task automatic run_to_idle();
    while (bus_ph != PH_IDLE) send_cmd(tick_cmd());
  endtask

  task automatic wait_results();
    in_push <= 1'b0;
    while (res_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(logic [7:0] ack, logic [7:0] hp);
    wait_results();
    cfg_we <= 1'b1;
    cfg_index <= CFG_ACK_TIMEOUT;
    cfg_wdata <= ack;
    @(posedge clk);
    cfg_index <= CFG_HALF_PERIOD;
    cfg_wdata <= hp;
    @(posedge clk);
    cfg_we <= 1'b0;
    ack_limit = ack;
    half_cfg = hp;
  endtask

  task automatic test_idle_levels();
    repeat (4) send_cmd(tick_cmd());
  endtask

  task automatic test_write_xfer();
    set_nack(4'b0, 0);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h5A);
    start_xfer(OP_BEGIN_WR, 8'hFF, 8'h00, 8'd3);
    run_to_idle();
  endtask

  task automatic test_read_xfer();
    start_xfer(OP_BEGIN_RD, 8'h00, 8'hFF, 8'd2);
    repeat (6) send_cmd(tick_cmd());
    start_xfer(OP_BEGIN_WR, 8'h12, 8'h34, 8'd0);
    push_byte(8'hC3);
    run_to_idle();
  endtask

  task automatic test_zero_count();
    start_xfer(OP_BEGIN_WR, 8'hA4, 8'h10, 8'd0);
    run_to_idle();
    start_xfer(OP_BEGIN_RD, 8'hA5, 8'h11, 8'd0);
    run_to_idle();
  endtask

  task automatic test_refusals();
    start_xfer(OP_BEGIN_WR, 8'h20, 8'h01, 8'd255);
    while (wr_fifo.size() < WFIFO_SLOTS) push_byte(8'($urandom_range(255)));
    push_byte(8'h77);
    start_xfer(OP_BEGIN_WR, 8'h20, 8'h02, 8'(WFIFO_SLOTS));
    run_to_idle();
  endtask

  task automatic test_nacks();
    configure(8'd0, 8'd1);
    repeat (3) push_byte(8'($urandom_range(255)));
    set_nack(4'b1 << K_ADDRW, 0);
    start_xfer(OP_BEGIN_WR, 8'h50, 8'h00, 8'd3);
    run_to_idle();
    repeat (3) push_byte(8'($urandom_range(255)));
    set_nack((4'b1 << K_REG) | (4'b1 << K_DATA), 0);
    start_xfer(OP_BEGIN_WR, 8'h51, 8'h01, 8'd3);
    run_to_idle();
    set_nack((4'b1 << K_REG) | (4'b1 << K_ADDRR), 0);
    start_xfer(OP_BEGIN_RD, 8'h52, 8'h02, 8'd2);
    run_to_idle();
    set_nack(4'b1 << K_ADDRW, 0);
    start_xfer(OP_BEGIN_RD, 8'h53, 8'h03, 8'd2);
    run_to_idle();
    configure(8'd255, 8'd1);
    start_xfer(OP_BEGIN_WR, 8'h54, 8'h04, 8'd0);
    run_to_idle();
    set_nack(4'b0, 60);
    repeat (2) push_byte(8'($urandom_range(255)));
    start_xfer(OP_BEGIN_WR, 8'h55, 8'h05, 8'd2);
    run_to_idle();
  endtask

  task automatic test_slow_phases();
    configure(8'd0, 8'd12);
    set_nack(4'b1 << K_ADDRW, 0);
    start_xfer(OP_BEGIN_WR, 8'hFE, 8'h7F, 8'd0);
    run_to_idle();
    configure(8'd3, 8'd0);
    set_nack(4'b0, 30);
    start_xfer(OP_BEGIN_RD, 8'h3C, 8'h80, 8'd3);
    run_to_idle();
  endtask

  task automatic test_long_read();
    configure(ACK_TIMEOUT_RST, HALF_PERIOD_RST);
    set_nack(4'b0, 0);
    start_xfer(OP_BEGIN_RD, 8'h91, 8'h42, 8'd16);
    run_to_idle();
  endtask

  task automatic test_backpressure();
    configure(ACK_TIMEOUT_RST, HALF_PERIOD_RST);
    send_idle_pct = 0;
    pop_stall_pct = 0;
    repeat (2) push_byte(8'($urandom_range(255)));
    start_xfer(OP_BEGIN_WR, 8'h6A, 8'h0F, 8'd2);
    hold_left = 64;
    repeat (40) send_cmd(tick_cmd());
    wait_results();
    run_to_idle();
  endtask

  task automatic test_random(int unsigned idle_pct, int unsigned stall_pct, int unsigned n_items);
    int unsigned first;
    logic [7:0]  cnt;
    op_t         op;
    cmd_t        c;
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    first = n_sent;
    while (n_sent - first < n_items) begin
      if ($urandom_range(3) == 0)
        configure(($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3)),
                  ($urandom_range(7) == 0) ? 8'($urandom_range(2, 4)) : 8'($urandom_range(1)));
      set_nack(($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'b0,
               $urandom_range(3) * 25);
      repeat ($urandom_range(4)) push_byte(8'($urandom_range(255)));
      repeat ($urandom_range(2)) send_cmd(tick_cmd());
      if ($urandom_range(4) < 3) begin
        op = OP_BEGIN_WR;
        cnt = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                       : 8'($urandom_range(wr_fifo.size()));
      end else begin
        op = OP_BEGIN_RD;
        cnt = ($urandom_range(9) == 0) ? 8'($urandom_range(4, 12)) : 8'($urandom_range(3));
      end
      start_xfer(op, 8'($urandom_range(255)), 8'($urandom_range(255)), cnt);
      while (bus_ph != PH_IDLE) begin
        if ($urandom_range(99) < 4) begin
          c = rand_cmd(op_t'($urandom_range(1, 3)));
          send_cmd(c);
        end else begin
          send_cmd(tick_cmd());
        end
      end
    end
    wait_results();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_left != 0) begin
      out_pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (res_due.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unrequested result at cycle %0d", cyc);
      end else begin
        want = res_due.pop_front();
        if (out_scl_level !== want.scl_level || out_sda_level !== want.sda_level ||
            out_sda_drive !== want.sda_drive || out_busy_res !== want.busy_res ||
            out_read_byte !== want.read_byte || out_read_valid !== want.read_valid ||
            out_done_res !== want.done_res || out_status !== want.status) begin
          n_err++;
          if (n_err <= 10) begin
            $display("mismatch at cycle %0d:", cyc);
            $display("  want scl=%b sda=%b drv=%b busy=%b rbyte=%h rv=%b done=%b st=%0d",
                     want.scl_level, want.sda_level, want.sda_drive, want.busy_res,
                     want.read_byte, want.read_valid, want.done_res, want.status);
            $display("  got  scl=%b sda=%b drv=%b busy=%b rbyte=%h rv=%b done=%b st=%0d",
                     out_scl_level, out_sda_level, out_sda_drive, out_busy_res,
                     out_read_byte, out_read_valid, out_done_res, out_status);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_levels();
    test_write_xfer();
    test_read_xfer();
    test_zero_count();
    test_refusals();
    test_nacks();
    test_slow_phases();
    test_long_read();
    test_backpressure();
    test_random(0, 0, 120);
    test_random(71, 0, 120);
    test_random(0, 71, 120);
    test_random(33, 33, 120);
    wait_results();
    $display("covered %0d transactions: %0d transfers done, %0d ended by nack, %0d bytes read",
             n_sent, n_done, n_nack, n_rbytes);
    $display("%0d commands refused, %0d failures seen", n_refused, n_err);
    if (n_err == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_queue.sv
hw/rtl/i2cm_front.sv
hw/rtl/i2cm_engine.sv
hw/rtl/i2c_master_register_access.sv
tb/sv/i2c_master_register_access_test.sv
